// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RAFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/rafa_pkg.sv
`timescale 1ns / 1ps

package rafa_pkg;

	localparam int SMP_W   = 12;
	localparam int SUM_W   = 20;
	localparam int AVG_W   = 12;
	localparam int VOLT_W  = 35;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;

	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 46;
	localparam int DVD_W   = 44;
	localparam int DSR_W   = 25;
	localparam int DIV_CNT_W = 6;

	localparam int REF_UV  = 1200000;
	localparam int SLOPE_UV_PER_C = 4300;
	localparam int T25_MC  = 25000;
	localparam int MILLI   = 1000;

	localparam logic [17:0] GAIN_A_RST = 18'd131351;
	localparam logic [17:0] GAIN_B_RST = 18'd132048;
	localparam logic [17:0] GAIN_C_RST = 18'd131769;
	localparam logic [23:0] COND_HI_RST = 24'd1729618;
	localparam logic [23:0] COND_LO_RST = 24'd35696;
	localparam logic signed [20:0] OFF_HI_RST = 21'sd150000;
	localparam logic signed [20:0] OFF_LO_RST = 21'sd2800;
	localparam logic [10:0] V25_RST = 11'd1405;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_A  = 3'd0,
		CFG_GAIN_B  = 3'd1,
		CFG_GAIN_C  = 3'd2,
		CFG_COND_HI = 3'd3,
		CFG_COND_LO = 3'd4,
		CFG_OFF_HI  = 3'd5,
		CFG_OFF_LO  = 3'd6,
		CFG_V25     = 3'd7
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AVG,
		ST_AVG_WR,
		ST_V_M1,
		ST_V_M2,
		ST_V_D,
		ST_V_WR,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_T5,
		ST_T6,
		ST_T7,
		ST_T_WR,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_S4,
		ST_S5,
		ST_S6,
		ST_S7,
		ST_DONE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [SMP_W-1:0] sample_a;
		logic [SMP_W-1:0] sample_b;
		logic [SMP_W-1:0] sample_c;
		logic [SMP_W-1:0] sample_temp;
		logic [SMP_W-1:0] sample_ref;
	} frame_t;

	typedef struct packed {
		logic [23:0]        voltage_uv;
		logic signed [31:0] current_high_na;
		logic signed [31:0] current_low_na;
		logic signed [23:0] temperature_mc;
		logic               ref_zero;
	} result_t;

endpackage

// File: rtl/ratiometric_adc_frame_averager.sv
`timescale 1ns / 1ps
// Ratiometric ADC frame averager.
// in_valid/in_ready/in_data: one scan frame (a, b, c, temperature, reference)
// per request. out_valid/out_ready/out_data: one result per FRAMES_PER_RESULT
// frames. cfg_we/cfg_index/cfg_data: register writes, taken at once. The user
// must write only while the block is idle; the block does not enforce it.
// Frames other than the last of a group are summed in the accept cycle;
// such frames can be taken every cycle. The last frame of a group starts a
// sequence run on one 36x24 multiplier and one restoring divider (one
// quotient bit per cycle, three divisions by the reference average and one
// for the temperature; the averages come from a reciprocal multiply). When
// the reference average is zero the sequence ends after the averages.
// in_ready is low during the sequence, so no frame of the next group is
// taken before the result is loaded into the output register.
// The result sits in an output register; a stalled receiver holds it while
// new frames are summed. A further finished result waits in the sequencer
// until the register frees, with in_ready low.
// Reset clears sums, frame count and output valid, and loads the register
// defaults. No memory, no clearing pass.
`include "assert_macros.svh"

module ratiometric_adc_frame_averager #(
	parameter int FRAMES_PER_RESULT = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  rafa_pkg::frame_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output rafa_pkg::result_t                  out_data,
	input  logic                               cfg_we,
	input  logic [rafa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rafa_pkg::CFG_W-1:0]         cfg_data
);

	localparam int CNT_W   = $clog2(FRAMES_PER_RESULT);
	localparam int SUM_W   = rafa_pkg::SUM_W;
	localparam int AVG_W   = rafa_pkg::AVG_W;
	localparam int VOLT_W  = rafa_pkg::VOLT_W;
	localparam int MUL_A_W = rafa_pkg::MUL_A_W;
	localparam int MUL_B_W = rafa_pkg::MUL_B_W;
	localparam int PROD_W  = rafa_pkg::PROD_W;
	localparam int ACC_W   = rafa_pkg::ACC_W;
	localparam int DVD_W   = rafa_pkg::DVD_W;
	localparam int DSR_W   = rafa_pkg::DSR_W;
	localparam int DIV_CNT_W = rafa_pkg::DIV_CNT_W;
	localparam logic [CNT_W-1:0] LAST_FRAME = CNT_W'(FRAMES_PER_RESULT - 1);
	// avg = (sum * ceil(2^k / N)) >> k, exact for every SUM_W-bit sum
	localparam int AVG_SHIFT = SUM_W + CNT_W;
	localparam logic [MUL_B_W-1:0] AVG_RECIP = MUL_B_W'(((longint'(1) << AVG_SHIFT)
		+ longint'(FRAMES_PER_RESULT) - 1) / longint'(FRAMES_PER_RESULT));

	rafa_pkg::state_t state_q, state_d, ret_q;
	logic [2:0]       sel_q;

	logic [17:0]        gain_a_q, gain_b_q, gain_c_q;
	logic [23:0]        cond_hi_q, cond_lo_q;
	logic signed [20:0] off_hi_q, off_lo_q;
	logic [10:0]        v25_q;

	logic [SUM_W-1:0] sum_a_q, sum_b_q, sum_c_q, sum_t_q, sum_r_q;
	logic [CNT_W-1:0] frame_cnt_q;

	logic [AVG_W-1:0]  avg_a_q, avg_b_q, avg_c_q, avg_t_q, avg_r_q;
	logic [VOLT_W-1:0] v_a_q, v_b_q, v_c_q;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [47:0]       p1_q;
	logic              neg_q;
	logic              zero_q;
	logic signed [23:0] temp_q;
	logic signed [31:0] cur_hi_q, cur_lo_q;

	logic [DVD_W-1:0]     div_quo_q;
	logic [DSR_W-1:0]     div_rem_q, div_dsr_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic              out_valid_q;
	rafa_pkg::result_t out_q;

	logic in_acc, last_frame, out_load;
	logic st_idle, out_clear;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [SUM_W-1:0]   sum_sel;
	logic [17:0]        gain_sel;
	logic [AVG_W-1:0]   avg_sel;
	logic [AVG_W-1:0]   avg_new;
	logic [23:0]        cond_sel;
	logic signed [20:0] off_sel;
	logic [VOLT_W-1:0]  vx_sel, vy_sel;

	logic [DSR_W:0]   rem_sh;
	logic [DSR_W+1:0] div_diff;
	logic             div_fits;

	logic signed [34:0] t_num;
	logic [34:0]        t_abs;
	logic signed [45:0] t_sq, t_val;
	logic signed [23:0] t_sat;
	logic signed [35:0] dv;
	logic [34:0]        dv_abs;
	logic [ACC_W-1:0]   s_q;
	logic signed [47:0] s_sq, s_val;
	logic signed [31:0] s_sat;
	logic [23:0]        v_sat;
	rafa_pkg::result_t  res;

	assign in_acc     = in_valid && in_ready;
	assign last_frame = (frame_cnt_q == LAST_FRAME);
	assign out_load   = (state_q == rafa_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign avg_new    = prod_q[AVG_SHIFT +: AVG_W];
	assign st_idle    = (state_q == rafa_pkg::ST_IDLE);
	assign out_clear  = (out_q.voltage_uv == '0) && (out_q.current_high_na == '0)
		&& (out_q.current_low_na == '0) && (out_q.temperature_mc == '0);

	always_comb begin
		case (sel_q)
			3'd0: begin
				sum_sel = sum_a_q; gain_sel = gain_a_q; avg_sel = avg_a_q;
			end
			3'd1: begin
				sum_sel = sum_b_q; gain_sel = gain_b_q; avg_sel = avg_b_q;
			end
			3'd2: begin
				sum_sel = sum_c_q; gain_sel = gain_c_q; avg_sel = avg_c_q;
			end
			3'd3: begin
				sum_sel = sum_t_q; gain_sel = '0; avg_sel = avg_t_q;
			end
			3'd4: begin
				sum_sel = sum_r_q; gain_sel = '0; avg_sel = avg_r_q;
			end
			default: begin
				sum_sel = '0; gain_sel = '0; avg_sel = '0;
			end
		endcase
		// sel 0: high shunt (a - b), sel 1: low shunt (b - c)
		cond_sel = sel_q[0] ? cond_lo_q : cond_hi_q;
		off_sel  = sel_q[0] ? off_lo_q : off_hi_q;
		vx_sel   = sel_q[0] ? v_b_q : v_a_q;
		vy_sel   = sel_q[0] ? v_c_q : v_b_q;
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			rafa_pkg::ST_AVG: begin
				mul_a = MUL_A_W'(sum_sel); mul_b = AVG_RECIP;
			end
			rafa_pkg::ST_V_M1: begin
				mul_a = MUL_A_W'(gain_sel); mul_b = MUL_B_W'(avg_sel);
			end
			rafa_pkg::ST_V_M2: begin
				mul_a = MUL_A_W'(prod_q[29:0]); mul_b = MUL_B_W'(rafa_pkg::REF_UV);
			end
			rafa_pkg::ST_T1: begin
				mul_a = MUL_A_W'(v25_q); mul_b = MUL_B_W'(rafa_pkg::MILLI);
			end
			rafa_pkg::ST_T2: begin
				mul_a = MUL_A_W'(prod_q[20:0]); mul_b = MUL_B_W'(avg_r_q);
			end
			rafa_pkg::ST_T3: begin
				mul_a = MUL_A_W'(avg_t_q); mul_b = MUL_B_W'(rafa_pkg::REF_UV);
			end
			rafa_pkg::ST_T5: begin
				mul_a = MUL_A_W'(acc_q[32:0]); mul_b = MUL_B_W'(rafa_pkg::MILLI);
			end
			rafa_pkg::ST_T6: begin
				mul_a = MUL_A_W'(avg_r_q); mul_b = MUL_B_W'(rafa_pkg::SLOPE_UV_PER_C);
			end
			rafa_pkg::ST_S2: begin
				mul_a = MUL_A_W'(acc_q[23:0]); mul_b = cond_sel;
			end
			rafa_pkg::ST_S3: begin
				mul_a = MUL_A_W'(acc_q[34:24]); mul_b = cond_sel;
			end
			rafa_pkg::ST_S5: begin
				mul_a = acc_q[35:0]; mul_b = MUL_B_W'(rafa_pkg::MILLI);
			end
			rafa_pkg::ST_S6: begin
				mul_a = MUL_A_W'(p1_q[23:0]); mul_b = MUL_B_W'(rafa_pkg::MILLI);
			end
			default: begin
				mul_a = '0; mul_b = '0;
			end
		endcase
	end

	// restoring divider step
	assign rem_sh   = {div_rem_q, div_quo_q[DVD_W-1]};
	assign div_diff = {1'b0, rem_sh} - {2'b00, div_dsr_q};
	assign div_fits = !div_diff[DSR_W+1];

	// temperature
	assign t_num = $signed({2'b00, acc_q[32:0]}) - $signed({2'b00, prod_q[32:0]});
	assign t_abs = t_num[34] ? 35'(-t_num) : 35'(t_num);
	assign t_sq  = $signed({2'b00, div_quo_q});
	assign t_val = (neg_q ? -t_sq : t_sq) + 46'(rafa_pkg::T25_MC);
	always_comb begin
		if (t_val > 46'sd8388607) begin
			t_sat = 24'sh7FFFFF;
		end else if (t_val < -46'sd8388608) begin
			t_sat = -24'sd8388608;
		end else begin
			t_sat = t_val[23:0];
		end
	end

	// shunt currents
	assign dv     = $signed({1'b0, vx_sel}) - $signed({1'b0, vy_sel});
	assign dv_abs = dv[35] ? 35'(-dv) : 35'(dv);
	assign s_q    = acc_q + ACC_W'(prod_q[33:24]);
	assign s_sq   = $signed({2'b00, s_q});
	assign s_val  = (neg_q ? -s_sq : s_sq) + {{27{off_sel[20]}}, off_sel};
	always_comb begin
		if (s_val > 48'sd2147483647) begin
			s_sat = 32'sh7FFFFFFF;
		end else if (s_val < -48'sd2147483648) begin
			s_sat = 32'sh80000000;
		end else begin
			s_sat = s_val[31:0];
		end
	end

	assign v_sat = (|v_c_q[VOLT_W-1:24]) ? 24'hFFFFFF : v_c_q[23:0];

	always_comb begin
		if (zero_q) begin
			res = '0;
			res.ref_zero = 1'b1;
		end else begin
			res.voltage_uv      = v_sat;
			res.current_high_na = cur_hi_q;
			res.current_low_na  = cur_lo_q;
			res.temperature_mc  = temp_q;
			res.ref_zero        = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == rafa_pkg::ST_IDLE);
		case (state_q)
			rafa_pkg::ST_IDLE: begin
				if (in_valid && last_frame) begin
					state_d = rafa_pkg::ST_AVG;
				end
			end
			rafa_pkg::ST_AVG:  state_d = rafa_pkg::ST_AVG_WR;
			rafa_pkg::ST_AVG_WR: begin
				if (sel_q == 3'd4) begin
					state_d = (avg_new == '0) ? rafa_pkg::ST_DONE
						: rafa_pkg::ST_V_M1;
				end else begin
					state_d = rafa_pkg::ST_AVG;
				end
			end
			rafa_pkg::ST_V_M1: state_d = rafa_pkg::ST_V_M2;
			rafa_pkg::ST_V_M2: state_d = rafa_pkg::ST_V_D;
			rafa_pkg::ST_V_D:  state_d = rafa_pkg::ST_DIV;
			rafa_pkg::ST_V_WR: begin
				state_d = (sel_q == 3'd2) ? rafa_pkg::ST_T1 : rafa_pkg::ST_V_M1;
			end
			rafa_pkg::ST_T1:   state_d = rafa_pkg::ST_T2;
			rafa_pkg::ST_T2:   state_d = rafa_pkg::ST_T3;
			rafa_pkg::ST_T3:   state_d = rafa_pkg::ST_T4;
			rafa_pkg::ST_T4:   state_d = rafa_pkg::ST_T5;
			rafa_pkg::ST_T5:   state_d = rafa_pkg::ST_T6;
			rafa_pkg::ST_T6:   state_d = rafa_pkg::ST_T7;
			rafa_pkg::ST_T7:   state_d = rafa_pkg::ST_DIV;
			rafa_pkg::ST_T_WR: state_d = rafa_pkg::ST_S1;
			rafa_pkg::ST_S1:   state_d = rafa_pkg::ST_S2;
			rafa_pkg::ST_S2:   state_d = rafa_pkg::ST_S3;
			rafa_pkg::ST_S3:   state_d = rafa_pkg::ST_S4;
			rafa_pkg::ST_S4:   state_d = rafa_pkg::ST_S5;
			rafa_pkg::ST_S5:   state_d = rafa_pkg::ST_S6;
			rafa_pkg::ST_S6:   state_d = rafa_pkg::ST_S7;
			rafa_pkg::ST_S7: begin
				state_d = sel_q[0] ? rafa_pkg::ST_DONE : rafa_pkg::ST_S1;
			end
			rafa_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = rafa_pkg::ST_IDLE;
				end
			end
			rafa_pkg::ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					state_d = ret_q;
				end
			end
			default: state_d = rafa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rafa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_a_q  <= rafa_pkg::GAIN_A_RST;
			gain_b_q  <= rafa_pkg::GAIN_B_RST;
			gain_c_q  <= rafa_pkg::GAIN_C_RST;
			cond_hi_q <= rafa_pkg::COND_HI_RST;
			cond_lo_q <= rafa_pkg::COND_LO_RST;
			off_hi_q  <= rafa_pkg::OFF_HI_RST;
			off_lo_q  <= rafa_pkg::OFF_LO_RST;
			v25_q     <= rafa_pkg::V25_RST;
		end else if (cfg_we) begin
			case (rafa_pkg::cfg_idx_t'(cfg_index))
				rafa_pkg::CFG_GAIN_A:  gain_a_q  <= cfg_data[17:0];
				rafa_pkg::CFG_GAIN_B:  gain_b_q  <= cfg_data[17:0];
				rafa_pkg::CFG_GAIN_C:  gain_c_q  <= cfg_data[17:0];
				rafa_pkg::CFG_COND_HI: cond_hi_q <= cfg_data;
				rafa_pkg::CFG_COND_LO: cond_lo_q <= cfg_data;
				rafa_pkg::CFG_OFF_HI:  off_hi_q  <= cfg_data[20:0];
				rafa_pkg::CFG_OFF_LO:  off_lo_q  <= cfg_data[20:0];
				rafa_pkg::CFG_V25:     v25_q     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// control: sums, counters, sequencer bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			sum_c_q     <= '0;
			sum_t_q     <= '0;
			sum_r_q     <= '0;
			frame_cnt_q <= '0;
			sel_q       <= '0;
			ret_q       <= rafa_pkg::ST_IDLE;
			div_cnt_q   <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				sum_a_q     <= sum_a_q + SUM_W'(in_data.sample_a);
				sum_b_q     <= sum_b_q + SUM_W'(in_data.sample_b);
				sum_c_q     <= sum_c_q + SUM_W'(in_data.sample_c);
				sum_t_q     <= sum_t_q + SUM_W'(in_data.sample_temp);
				sum_r_q     <= sum_r_q + SUM_W'(in_data.sample_ref);
				frame_cnt_q <= last_frame ? '0 : frame_cnt_q + 1'b1;
				sel_q       <= '0;
			end
			case (state_q)
				rafa_pkg::ST_V_D: begin
					ret_q <= rafa_pkg::ST_V_WR;
					div_cnt_q <= '0;
				end
				rafa_pkg::ST_T7: begin
					ret_q <= rafa_pkg::ST_T_WR;
					div_cnt_q <= '0;
				end
				rafa_pkg::ST_DIV: div_cnt_q <= div_cnt_q + 1'b1;
				rafa_pkg::ST_AVG_WR: begin
					if (sel_q == 3'd4) begin
						sel_q   <= '0;
						zero_q  <= (avg_new == '0);
						sum_a_q <= '0;
						sum_b_q <= '0;
						sum_c_q <= '0;
						sum_t_q <= '0;
						sum_r_q <= '0;
					end else begin
						sel_q <= sel_q + 3'd1;
					end
				end
				rafa_pkg::ST_V_WR: sel_q <= (sel_q == 3'd2) ? 3'd0 : sel_q + 3'd1;
				rafa_pkg::ST_T_WR: sel_q <= '0;
				rafa_pkg::ST_S7:   sel_q <= 3'd1;
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (state_q)
			rafa_pkg::ST_V_D: begin
				div_quo_q <= DVD_W'(prod_q[50:16]);
				div_dsr_q <= DSR_W'(avg_r_q);
				div_rem_q <= '0;
			end
			rafa_pkg::ST_T7: begin
				div_quo_q <= acc_q[DVD_W-1:0];
				div_dsr_q <= prod_q[DSR_W-1:0];
				div_rem_q <= '0;
			end
			rafa_pkg::ST_DIV: begin
				div_rem_q <= div_fits ? div_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
				div_quo_q <= {div_quo_q[DVD_W-2:0], div_fits};
			end
			rafa_pkg::ST_AVG_WR: begin
				case (sel_q)
					3'd0: avg_a_q <= avg_new;
					3'd1: avg_b_q <= avg_new;
					3'd2: avg_c_q <= avg_new;
					3'd3: avg_t_q <= avg_new;
					3'd4: avg_r_q <= avg_new;
					default: ;
				endcase
			end
			rafa_pkg::ST_V_WR: begin
				case (sel_q)
					3'd0: v_a_q <= div_quo_q[VOLT_W-1:0];
					3'd1: v_b_q <= div_quo_q[VOLT_W-1:0];
					3'd2: v_c_q <= div_quo_q[VOLT_W-1:0];
					default: ;
				endcase
			end
			rafa_pkg::ST_T3: acc_q <= ACC_W'(prod_q[32:0]);
			rafa_pkg::ST_T4: begin
				neg_q <= t_num[34];
				acc_q <= ACC_W'(t_abs);
			end
			rafa_pkg::ST_T6: acc_q <= ACC_W'(prod_q[43:0]);
			rafa_pkg::ST_T_WR: temp_q <= t_sat;
			rafa_pkg::ST_S1: begin
				neg_q <= dv[35];
				acc_q <= ACC_W'(dv_abs);
			end
			rafa_pkg::ST_S3: p1_q <= prod_q[47:0];
			rafa_pkg::ST_S4: acc_q <= ACC_W'(prod_q[34:0]) + ACC_W'(p1_q[47:24]);
			rafa_pkg::ST_S6: acc_q <= prod_q[ACC_W-1:0];
			rafa_pkg::ST_S7: begin
				if (sel_q[0]) begin
					cur_lo_q <= s_sat;
				end else begin
					cur_hi_q <= s_sat;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q <= res;
		end
	end

	`RAFA_ASSERT_NXT(a_mid_frame_stays_idle, clk, arst_n, in_acc && !last_frame, st_idle)
	`RAFA_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == rafa_pkg::ST_DIV, div_dsr_q != '0)
	`RAFA_ASSERT_IMP(a_zero_result, clk, arst_n, out_valid_q && out_q.ref_zero, out_clear)
	`RAFA_ASSERT_NXT(a_load_sets_valid, clk, arst_n, out_load, out_valid_q && st_idle)

endmodule
